>>> rtl/lzwc_pkg.sv
// lzwc_pkg: shared constants, item and command types for the LZW compressor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lzwc_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int CW_W          = $clog2(MAX_CODE_BITS + 1);
  localparam int KEY_W         = CODE_W + 8;
  localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
  localparam int EPOCH_W       = 8;
  localparam int ACC_W         = CODE_W + 8;
  localparam int FILL_W        = $clog2(ACC_W + 1);

  localparam logic [CODE_W-1:0] CLEAR_CODE  = CODE_W'(256);
  localparam logic [CODE_W-1:0] END_CODE    = CODE_W'(257);
  localparam logic [CODE_W-1:0] TOP_CODE    = {CODE_W{1'b1}};
  localparam logic [CW_W-1:0]   FIRST_WIDTH = CW_W'(9);
  localparam logic [31:0]       HASH_MULT   = 32'd2654435761;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_CODE       = 2'd0;
  localparam cmd_kind_t CMD_ITEM_END   = 2'd1;
  localparam cmd_kind_t CMD_STREAM_END = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] value;
    logic [CW_W-1:0]   width;
  } pack_cmd_t;
endpackage

>>> rtl/lzwc_ifs.sv
// lzwc_ifs: valid/ready channel interfaces for input items and output bytes.
// No dependencies.
`timescale 1ns / 1ps
interface lzwc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, op, data_byte, input ready);
  modport sink   (input valid, op, data_byte, output ready);
endinterface

interface lzwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;
  modport source (output valid, out_byte, run_last, stream_done, input ready);
  modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

>>> rtl/lzwc_front.sv
// lzwc_front: accepts input requests and queues them in a two-entry FIFO.
// Depends on lzwc_pkg and lzwc_in_if.
`timescale 1ns / 1ps
module lzwc_front import lzwc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  lzwc_in_if.sink in_ch,
  output item_t  q_item,
  output logic   q_valid,
  input  logic   q_pop
);
  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      in_item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = slot_r[rd_ptr_r];

  // end requests carry no byte
  always_comb begin
    in_item.op        = in_ch.op;
    in_item.data_byte = (in_ch.op == OP_END) ? 8'd0 : in_ch.data_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end
endmodule

>>> rtl/lzwc_dict.sv
// lzwc_dict: dictionary engine; hashed lookup with linear probing, code
// assignment, width growth and restart. Depends on lzwc_pkg.
`timescale 1ns / 1ps
module lzwc_dict import lzwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     q_item,
  input  logic      q_valid,
  output logic      q_pop,
  output pack_cmd_t cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);
  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_WAIT     = 4'd3;
  localparam logic [3:0] S_CMP      = 4'd4;
  localparam logic [3:0] S_EMIT_PFX = 4'd5;
  localparam logic [3:0] S_EMIT_CLR = 4'd6;
  localparam logic [3:0] S_IEND     = 4'd7;
  localparam logic [3:0] S_END_PFX  = 4'd8;
  localparam logic [3:0] S_END_CODE = 4'd9;
  localparam logic [3:0] S_END_FIN  = 4'd10;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  code;
  } ent_t;

  ent_t mem [DICT_DEPTH];
  ent_t rd_q;

  logic [3:0]         state_r, state_nxt;
  logic [CODE_W-1:0]  slot_r, slot_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic [CODE_W-1:0]  prefix_r, prefix_nxt;
  logic               present_r, present_nxt;
  logic               started_r, started_nxt;
  logic [CODE_W-1:0]  next_r, next_nxt;
  logic [CW_W-1:0]    width_r, width_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               sweep_pend_r, sweep_pend_nxt;
  logic [CODE_W-1:0]  sweep_idx_r, sweep_idx_nxt;
  pack_cmd_t          cmd_r, cmd_nxt;
  logic               cmd_v_r, cmd_v_nxt;

  logic               can_emit, emit;
  pack_cmd_t          emit_cmd;
  logic               we;
  logic [CODE_W-1:0]  wa;
  ent_t               wd;
  logic [KEY_W-1:0]   key_in;
  logic [CODE_W-1:0]  fresh;
  logic [CODE_W:0]    pow;
  logic               ent_live;

  assign can_emit  = !cmd_v_r || cmd_ready;
  assign cmd       = cmd_r;
  assign cmd_valid = cmd_v_r;
  assign key_in    = {prefix_r, q_item.data_byte};
  assign fresh     = next_r + CODE_W'(1);
  assign pow       = (CODE_W+1)'(1) << width_r;
  assign ent_live  = (rd_q.epoch == epoch_r);

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    key_nxt        = key_r;
    prod_nxt       = prod_r;
    prefix_nxt     = prefix_r;
    present_nxt    = present_r;
    started_nxt    = started_r;
    next_nxt       = next_r;
    width_nxt      = width_r;
    epoch_nxt      = epoch_r;
    sweep_pend_nxt = sweep_pend_r;
    sweep_idx_nxt  = sweep_idx_r;
    q_pop          = 1'b0;
    emit           = 1'b0;
    emit_cmd       = '0;
    we             = 1'b0;
    wa             = slot_r;
    wd             = '{epoch: epoch_r, key: key_r, code: fresh};

    unique case (state_r)
      S_SWEEP: begin
        we            = 1'b1;
        wa            = sweep_idx_r;
        wd            = '0;
        sweep_idx_nxt = sweep_idx_r + CODE_W'(1);
        if (sweep_idx_r == TOP_CODE) begin
          epoch_nxt      = EPOCH_W'(1);
          sweep_pend_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          if (!started_r) begin
            if (can_emit) begin
              emit        = 1'b1;
              emit_cmd    = '{kind: CMD_CODE, value: CLEAR_CODE, width: width_r};
              started_nxt = 1'b1;
            end
          end else if (q_item.op == OP_END) begin
            state_nxt = S_END_PFX;
          end else if (!present_r) begin
            prefix_nxt  = CODE_W'(q_item.data_byte);
            present_nxt = 1'b1;
            state_nxt   = S_IEND;
          end else begin
            key_nxt   = key_in;
            prod_nxt  = 32'(key_in * HASH_MULT);
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        slot_nxt  = prod_r[31 -: CODE_W];
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (ent_live && rd_q.key == key_r) begin
          prefix_nxt = rd_q.code;
          state_nxt  = S_IEND;
        end else if (ent_live) begin
          slot_nxt  = slot_r + CODE_W'(1);
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_EMIT_PFX;
        end
      end
      S_EMIT_PFX: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_cmd = '{kind: CMD_CODE, value: prefix_r, width: width_r};
          we       = 1'b1;
          next_nxt = fresh;
          if ({1'b0, fresh} == pow) begin
            width_nxt = width_r + CW_W'(1);
          end
          if (fresh == TOP_CODE) begin
            state_nxt = S_EMIT_CLR;
          end else begin
            prefix_nxt = CODE_W'(key_r[7:0]);
            state_nxt  = S_IEND;
          end
        end
      end
      S_EMIT_CLR: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_cmd   = '{kind: CMD_CODE, value: CLEAR_CODE, width: width_r};
          width_nxt  = FIRST_WIDTH;
          next_nxt   = END_CODE;
          prefix_nxt = CODE_W'(key_r[7:0]);
          if (epoch_r == {EPOCH_W{1'b1}}) begin
            sweep_pend_nxt = 1'b1;
          end else begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
          end
          state_nxt = S_IEND;
        end
      end
      S_IEND: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_cmd  = '{kind: CMD_ITEM_END, value: '0, width: '0};
          q_pop     = 1'b1;
          state_nxt = sweep_pend_r ? S_SWEEP : S_IDLE;
        end
      end
      S_END_PFX: begin
        if (!present_r) begin
          state_nxt = S_END_CODE;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_cmd  = '{kind: CMD_CODE, value: prefix_r, width: width_r};
          state_nxt = S_END_CODE;
        end
      end
      S_END_CODE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_cmd  = '{kind: CMD_CODE, value: END_CODE, width: width_r};
          state_nxt = S_END_FIN;
        end
      end
      S_END_FIN: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_cmd    = '{kind: CMD_STREAM_END, value: '0, width: '0};
          q_pop       = 1'b1;
          width_nxt   = FIRST_WIDTH;
          next_nxt    = END_CODE;
          prefix_nxt  = '0;
          present_nxt = 1'b0;
          started_nxt = 1'b0;
          if (epoch_r == {EPOCH_W{1'b1}}) begin
            sweep_pend_nxt = 1'b1;
            state_nxt      = S_SWEEP;
          end else begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
            state_nxt = sweep_pend_r ? S_SWEEP : S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      cmd_nxt   = emit_cmd;
      cmd_v_nxt = 1'b1;
    end else begin
      cmd_nxt   = cmd_r;
      cmd_v_nxt = cmd_v_r && !cmd_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      prefix_r     <= '0;
      present_r    <= 1'b0;
      started_r    <= 1'b0;
      next_r       <= END_CODE;
      width_r      <= FIRST_WIDTH;
      epoch_r      <= '0;
      sweep_pend_r <= 1'b1;
      sweep_idx_r  <= '0;
      cmd_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prefix_r     <= prefix_nxt;
      present_r    <= present_nxt;
      started_r    <= started_nxt;
      next_r       <= next_nxt;
      width_r      <= width_nxt;
      epoch_r      <= epoch_nxt;
      sweep_pend_r <= sweep_pend_nxt;
      sweep_idx_r  <= sweep_idx_nxt;
      cmd_v_r      <= cmd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    cmd_r  <= cmd_nxt;
  end

  // dictionary store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[slot_r];
  end

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    width_r >= FIRST_WIDTH && width_r <= CW_W'(MAX_CODE_BITS))
    else $error("code width out of range");
  // the top code is held only while the clear code goes out
  a_next_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    next_r == TOP_CODE |-> state_r == S_EMIT_CLR)
    else $error("dictionary not restarted at top code");
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> !q_pop)
    else $error("request retired during sweep");
endmodule

>>> rtl/lzwc_pack.sv
// lzwc_pack: bit packer; places codes MSB first into bytes filled from bit 0,
// holds one byte back to flag the last byte of a request. Depends on lzwc_pkg.
`timescale 1ns / 1ps
module lzwc_pack import lzwc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pack_cmd_t    cmd,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  lzwc_out_if.source   out_ch
);
  localparam int IDX_W = $clog2(CODE_W);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              od_r, od_nxt;
  logic              ov_r, ov_nxt;
  logic              out_free;

  function automatic logic [CODE_W-1:0] rev_code(input logic [CODE_W-1:0] value,
                                                 input logic [CW_W-1:0] width);
    logic [CODE_W-1:0] r;
    logic [CW_W-1:0]   idx;
    r = '0;
    for (int j = 0; j < CODE_W; j++) begin
      idx = width - CW_W'(1) - CW_W'(j);
      if (CW_W'(j) < width) begin
        r[j] = value[idx[IDX_W-1:0]];
      end
    end
    return r;
  endfunction

  assign out_free           = !ov_r || out_ch.ready;
  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.run_last    = ol_r;
  assign out_ch.stream_done = od_r;

  always_comb begin
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    od_nxt     = od_r;
    ov_nxt     = ov_r && !out_ch.ready;
    cmd_ready  = 1'b0;

    if (cnt_r >= FILL_W'(8)) begin
      if (!pend_v_r || out_free) begin
        if (pend_v_r) begin
          ob_nxt = pend_r;
          ol_nxt = 1'b0;
          od_nxt = 1'b0;
          ov_nxt = 1'b1;
        end
        pend_nxt   = acc_r[7:0];
        pend_v_nxt = 1'b1;
        acc_nxt    = acc_r >> 8;
        cnt_nxt    = cnt_r - FILL_W'(8);
      end
    end else if (cmd_valid) begin
      case (cmd.kind)
        CMD_CODE: begin
          acc_nxt   = acc_r | (ACC_W'(rev_code(cmd.value, cmd.width)) << cnt_r);
          cnt_nxt   = cnt_r + FILL_W'(cmd.width);
          cmd_ready = 1'b1;
        end
        CMD_ITEM_END, CMD_STREAM_END: begin
          if (cmd.kind == CMD_STREAM_END && cnt_r != '0) begin
            // pad the partial byte with zeros
            cnt_nxt = FILL_W'(8);
          end else if (!pend_v_r) begin
            cmd_ready = 1'b1;
          end else if (out_free) begin
            ob_nxt     = pend_r;
            ol_nxt     = 1'b1;
            od_nxt     = (cmd.kind == CMD_STREAM_END);
            ov_nxt     = 1'b1;
            pend_v_nxt = 1'b0;
            cmd_ready  = 1'b1;
          end
        end
        default: begin
          cmd_ready = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    od_r   <= od_nxt;
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r |-> ol_r)
    else $error("stream end not flagged as last byte");
endmodule

>>> rtl/lzw_byte_compressor.sv
// lzw_byte_compressor: top level of the LZW byte compressor.
// Depends on lzwc_pkg, lzwc_ifs, lzwc_front, lzwc_dict and lzwc_pack.
`timescale 1ns / 1ps
// Usage:
//  in_ch  : valid/ready requests; op=0 carries data_byte, op=1 ends the stream.
//  out_ch : valid/ready packed bytes; run_last marks the last byte a request
//           produced, stream_done the final padded byte of the stream.
//  A request can produce zero to four bytes. The first request of a stream
//  sends the clear code first; the end request flushes prefix, end code, pad.
// Timing:
//  Requests enter a two-entry FIFO, so in_ch keeps accepting until both are
//  full while the engine works and while out_ch is stalled. The dictionary
//  engine handles one request at a time: a byte needing a lookup goes through
//  hash multiply, memory read, compare, code issue and request close, plus a
//  read and compare per extra probe of the linearly probed table; an end
//  request issues prefix, end code and stream end in turn.
//  Registered output bytes leave at up to one per cycle while out_ch is ready.
// Reset (synchronous, rst_n low) clears control state, then a sweep clears
//  all 4096 dictionary tags; requests queue but are not processed.
//  The same sweep runs again after 255 dictionary restarts (tag wrap).
// A stalled receiver backs up the packer, then the engine, then in_ch.
module lzw_byte_compressor import lzwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lzwc_in_if.sink     in_ch,
  lzwc_out_if.source  out_ch
);
  item_t     q_item;
  logic      q_valid;
  logic      q_pop;
  pack_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_ready;

  // front: accept and queue
  lzwc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: dictionary match, code assignment, restarts
  lzwc_dict u_dict (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // bit packing and output register
  lzwc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );
endmodule

>>> dv/lzw_byte_compressor_tb.sv
// lzw_byte_compressor_tb: self-checking bench for the LZW byte compressor.
// Depends on lzwc_pkg, lzwc_ifs and the lzw_byte_compressor RTL.
`timescale 1ns / 1ps

// Tracks the compressor state in software and queues the bytes each request
// should produce; compares every output byte against the oldest one queued.
class lzw_scoreboard;
  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } packed_byte_t;

  packed_byte_t byte_q[$];
  int           errors;

  int         code_of[int];  // (prefix << 8 | byte) -> code
  int         next_code;
  int         code_width;
  int         prefix_code;
  bit         have_prefix;
  bit         started;
  bit [7:0]   acc;
  int         fill;
  bit [7:0]   pend[$];

  function new();
    errors = 0;
    reset_stream();
  endfunction

  function void restart_dict();
    code_of.delete();
    code_width = 9;
    next_code  = lzwc_pkg::END_CODE;
  endfunction

  function void reset_stream();
    restart_dict();
    prefix_code = 0;
    have_prefix = 0;
    started     = 0;
    acc         = '0;
    fill        = 0;
  endfunction

  // MSB of the code first, each byte filled from bit 0 upward
  function void put_code(int value, int width);
    for (int i = width - 1; i >= 0; i--) begin
      acc[fill] = (value >> i) & 1;
      fill++;
      if (fill == 8) begin
        pend.push_back(acc);
        acc  = '0;
        fill = 0;
      end
    end
  endfunction

  function void note_request(logic op, logic [7:0] data);
    int key;
    int fresh;
    bit done;
    done = 0;
    pend.delete();
    if (!started) begin
      put_code(lzwc_pkg::CLEAR_CODE, code_width);
      started = 1;
    end
    if (op == lzwc_pkg::OP_DATA) begin
      if (!have_prefix) begin
        prefix_code = data;
        have_prefix = 1;
      end else begin
        key = (prefix_code << 8) | data;
        if (code_of.exists(key)) begin
          prefix_code = code_of[key];
        end else begin
          put_code(prefix_code, code_width);
          fresh = next_code + 1;
          if (fresh == (1 << code_width)) code_width++;
          code_of[key] = fresh;
          next_code    = fresh;
          // table full: send clear and start over
          if (fresh + 1 == (1 << lzwc_pkg::MAX_CODE_BITS)) begin
            put_code(lzwc_pkg::CLEAR_CODE, code_width);
            restart_dict();
          end
          prefix_code = data;
        end
      end
    end else begin
      if (have_prefix) put_code(prefix_code, code_width);
      put_code(lzwc_pkg::END_CODE, code_width);
      if (fill != 0) pend.push_back(acc);
      done = 1;
      reset_stream();
    end
    foreach (pend[k]) begin
      packed_byte_t e;
      e.out_byte    = pend[k];
      e.run_last    = (k == pend.size() - 1);
      e.stream_done = e.run_last && done;
      byte_q.push_back(e);
    end
  endfunction

  function void check_result(logic [7:0] ob, logic rl, logic sd);
    packed_byte_t e;
    if (byte_q.size() == 0) begin
      $error("out_byte: unexpected byte %0h, none pending", ob);
      errors++;
      return;
    end
    e = byte_q.pop_front();
    if (ob !== e.out_byte) begin
      $error("out_byte: expected %0h, got %0h", e.out_byte, ob);
      errors++;
    end
    if (rl !== e.run_last) begin
      $error("run_last: expected %0b, got %0b", e.run_last, rl);
      errors++;
    end
    if (sd !== e.stream_done) begin
      $error("stream_done: expected %0b, got %0b", e.stream_done, sd);
      errors++;
    end
  endfunction

  function int pending();
    return byte_q.size();
  endfunction
endclass

module lzw_byte_compressor_tb;
  import lzwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // covers the post-reset tag sweep
  localparam int RANDOM_ITEMS   = 50;
  localparam int LONG_STREAM    = 280;    // enough fresh pairs to widen codes

  logic clk;
  logic rst_n;

  lzwc_in_if  in_if();
  lzwc_out_if out_if();

  lzw_byte_compressor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  lzw_scoreboard sb = new();

  bit stim_done;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request; inputs move on the falling edge. valid stays high
  // across back-to-back requests so it is never dropped and raised at once.
  task automatic send_request(logic op, logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.op        = op;
    in_if.data_byte = data;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    sb.note_request(op, data);
    @(negedge clk);
  endtask

  task automatic send_stream(int len, logic [7:0] mask);
    for (int i = 0; i < len; i++) send_request(OP_DATA, 8'($urandom()) & mask);
    send_request(OP_END, 8'($urandom()));
  endtask

  // Output side: random backpressure, check on every accepted byte
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_byte, out_if.run_last, out_if.stream_done);
  end

  // Watchdog: cycles with no handshake on either side while work remains
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (stim_done && sb.pending() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lzw_byte_compressor_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int count;
    int len;
    logic [7:0] mask;
    stim_done       = 1'b0;
    idle_cycles     = 0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_DATA;
    in_if.data_byte = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: end on an empty stream (clear, end code, pad)
    send_request(OP_END, 8'hFF);
    // single byte stream
    send_request(OP_DATA, 8'h80);
    send_request(OP_END, 8'h00);
    // extremes alternating
    for (int i = 0; i < 6; i++) send_request(OP_DATA, (i % 2) ? 8'hFF : 8'h00);
    send_request(OP_END, 8'h00);
    // repeated byte builds growing matches; end carries an ignored byte
    for (int i = 0; i < 9; i++) send_request(OP_DATA, 8'h55);
    send_request(OP_END, 8'hAA);

    // Random streams, mostly small alphabets so matches grow
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(OP_END, 8'($urandom()));  // empty stream
        count++;
      end else begin
        len  = $urandom_range(1, 30);
        mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)) | 8'h01;
        send_stream(len, mask);
        count += len + 1;
      end
    end

    // Long full-entropy stream: mostly misses, code width grows past 9
    send_stream(LONG_STREAM, 8'hFF);

    in_if.valid = 1'b0;
    stim_done   = 1'b1;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lzw_byte_compressor_tb: done, clean");
    end else begin
      $display("lzw_byte_compressor_tb: done, errors");
    end
    $finish;
  end
endmodule
